### rtl/ctsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsb_pkg
// Shared types and constants of the Cartesian tree stack builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsb_pkg;

  localparam int MaxNodes = 64;
  localparam int ValW     = 64;
  localparam int IdxW     = 7;

  localparam logic KindEdge = 1'b0;
  localparam logic KindRoot = 1'b1;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   set_end;
  } in_word_t;

  typedef struct packed {
    logic            record_kind;
    logic [IdxW-1:0] parent_node;
    logic [IdxW-1:0] child_node;
    logic            overflow;
    logic            last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] value;
  } spine_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic drop;
    logic pop;
    logic load_top;
    logic push;
    logic chain_start;
    logic chain_load;
    logic chain_emit;
    logic root;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic depth_nz;
    logic beats;
    logic last_nz;
    logic set_end;
    logic out_free;
    logic chain_more;
    logic chain_next;
  } stat_t;

endpackage

`default_nettype wire

### rtl/ctsb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsb_ctrl
// Sequencer: compare/pop loop, push or drop, spine chain read-out and root record.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ctsb_pkg::stat_t stat_i,
  output ctsb_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_LOAD,
    ST_CH_START,
    ST_CH_LOAD,
    ST_CH_EMIT,
    ST_ROOT
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (stat_i.full) begin
          cmd_o.drop = 1'b1;
          state_d    = stat_i.set_end ? ST_CH_START : ST_IDLE;
        end else if (stat_i.depth_nz && stat_i.beats) begin
          if (!stat_i.last_nz || stat_i.out_free) begin
            cmd_o.pop = 1'b1;
            state_d   = ST_LOAD;
          end
        end else if (!stat_i.last_nz || stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = stat_i.set_end ? ST_CH_START : ST_IDLE;
        end
      end
      ST_LOAD: begin
        cmd_o.load_top = 1'b1;
        state_d        = ST_COMPARE;
      end
      ST_CH_START: begin
        cmd_o.chain_start = 1'b1;
        state_d           = ST_CH_LOAD;
      end
      ST_CH_LOAD: begin
        cmd_o.chain_load = 1'b1;
        state_d          = stat_i.chain_more ? ST_CH_EMIT : ST_ROOT;
      end
      ST_CH_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.chain_emit = 1'b1;
          state_d          = stat_i.chain_next ? ST_CH_EMIT : ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (stat_i.out_free) begin
          cmd_o.root = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/ctsb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsb_datapath
// Spine stack memory, cached top entry, counters and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsb_datapath #(
  parameter int MAX_NODES = ctsb_pkg::MaxNodes
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctsb_pkg::in_word_t in_word_i,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire ctsb_pkg::cmd_t     cmd_i,
  output ctsb_pkg::stat_t         stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ctsb_pkg::out_word_t     out_word_o
);

  localparam int DW = $clog2(MAX_NODES + 1);
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int IW = ctsb_pkg::IdxW;

  // Spine memory
  ctsb_pkg::spine_entry_t spine_mem_q [MAX_NODES];
  ctsb_pkg::spine_entry_t rd_q;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;

  // Control state
  logic [DW-1:0] depth_q, count_q, k_q;
  logic          dropped_q, min_heap_q, end_q, out_valid_q;
  logic [IW-1:0] last_q;

  // Payload
  logic signed [ctsb_pkg::ValW-1:0] val_q;
  ctsb_pkg::spine_entry_t           top_q;
  logic [IW-1:0]                    prev_q, root_q;
  ctsb_pkg::out_word_t              out_word_q;

  logic [IW-1:0]       new_idx;
  logic [DW-1:0]       depth_m2, k_p1;
  logic                emit;
  ctsb_pkg::out_word_t rec;

  assign new_idx  = IW'(count_q) + IW'(1);
  assign depth_m2 = depth_q - DW'(2);
  assign k_p1     = k_q + DW'(1);

  assign stat_o.full       = (count_q == DW'(MAX_NODES));
  assign stat_o.depth_nz   = (depth_q != '0);
  assign stat_o.beats      = min_heap_q ? (top_q.value > val_q) : (top_q.value < val_q);
  assign stat_o.last_nz    = (last_q != '0);
  assign stat_o.set_end    = end_q;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign stat_o.chain_more = (k_q < depth_q);
  assign stat_o.chain_next = (k_p1 < depth_q);

  // Read port: next top on a pop, then bottom upwards for the chain
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.pop && (depth_q > DW'(1))) begin
      rd_en   = 1'b1;
      rd_addr = depth_m2[AW-1:0];
    end else if (cmd_i.chain_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd_i.chain_load && stat_o.chain_more) begin
      rd_en   = 1'b1;
      rd_addr = k_q[AW-1:0];
    end else if (cmd_i.chain_emit && stat_o.chain_next) begin
      rd_en   = 1'b1;
      rd_addr = k_p1[AW-1:0];
    end
  end

  assign wr_en = cmd_i.push && (depth_q < DW'(MAX_NODES));

  // Record to send this cycle
  always_comb begin
    emit            = 1'b0;
    rec             = '0;
    rec.record_kind = ctsb_pkg::KindEdge;
    if (cmd_i.pop && stat_o.last_nz) begin
      emit            = 1'b1;
      rec.parent_node = top_q.idx;
      rec.child_node  = last_q;
    end else if (cmd_i.push && stat_o.last_nz) begin
      emit            = 1'b1;
      rec.parent_node = new_idx;
      rec.child_node  = last_q;
      rec.last_of_run = !end_q;
    end else if (cmd_i.chain_emit) begin
      emit            = 1'b1;
      rec.parent_node = prev_q;
      rec.child_node  = rd_q.idx;
    end else if (cmd_i.root) begin
      emit            = 1'b1;
      rec.record_kind = ctsb_pkg::KindRoot;
      rec.child_node  = stat_o.depth_nz ? root_q : '0;
      rec.overflow    = dropped_q;
      rec.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      spine_mem_q[depth_q[AW-1:0]] <= '{idx: new_idx, value: val_q};
    end
    if (rd_en) begin
      rd_q <= spine_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      min_heap_q  <= 1'b1;
      end_q       <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_heap_q <= cfg_wdata_i;
      end
      if (cmd_i.load_item) begin
        end_q  <= in_word_i.set_end;
        last_q <= '0;
      end
      if (cmd_i.drop) begin
        dropped_q <= 1'b1;
      end
      if (cmd_i.pop) begin
        last_q  <= top_q.idx;
        depth_q <= depth_q - DW'(1);
      end
      if (cmd_i.push) begin
        count_q <= count_q + DW'(1);
        if (wr_en) begin
          depth_q <= depth_q + DW'(1);
        end
      end
      if (cmd_i.root) begin
        depth_q   <= '0;
        count_q   <= '0;
        dropped_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      val_q <= in_word_i.value;
    end
    if (cmd_i.push) begin
      top_q <= '{idx: new_idx, value: val_q};
    end
    if (cmd_i.load_top) begin
      top_q <= rd_q;
    end
    if (cmd_i.chain_start) begin
      k_q <= DW'(1);
    end
    if (cmd_i.chain_load) begin
      prev_q <= rd_q.idx;
      root_q <= rd_q.idx;
    end
    if (cmd_i.chain_emit) begin
      prev_q <= rd_q.idx;
      if (stat_o.chain_next) begin
        k_q <= k_p1;
      end
    end
    if (emit) begin
      out_word_q <= rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_depth_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= count_q) else $error("spine deeper than node count");

  a_count_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DW'(MAX_NODES)) else $error("node count beyond capacity");

  a_root_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.root |=> (depth_q == '0) && (count_q == '0) && !dropped_q)
    else $error("set state not cleared after root record");

  a_edge_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && rec.record_kind == ctsb_pkg::KindEdge) |->
      (rec.parent_node != '0) && (rec.child_node != '0) && !rec.overflow)
    else $error("malformed edge record");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("record issued over a stalled word");
`endif

endmodule

`default_nettype wire

### rtl/cartesian_tree_stack_builder.sv
`timescale 1ns / 1ps
// Per word the sequencer loads the word, compares it with the cached top and, for each pop,
// loads the next top and compares again, then pushes it (or drops it when the set is full);
// a closing word then reads the spine chain out bottom first and sends the root record.
// Each node is pushed once and popped at most once, so a long set is bound by the single
// read port of the spine memory and the one-compare-per-pop loop.
// Reset (rst_ni, asynchronous, active low) empties the set and selects min-heap order.
// ----------------------------------------------------------------------------
// cartesian_tree_stack_builder
// Builds the Cartesian tree of a sequence of signed keys with a right-spine
// stack and streams its parent/child edges followed by a root record.
// The spine memory is not cleared; the block accepts words from the first
// cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_tree_stack_builder #(
  parameter int MAX_NODES = ctsb_pkg::MaxNodes
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input words
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ctsb_pkg::in_word_t  in_word_i,
  // result words
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ctsb_pkg::out_word_t      out_word_o,
  // mode register: 1 min-heap, 0 max-heap
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i
);

  ctsb_pkg::cmd_t  cmd;
  ctsb_pkg::stat_t stat;

  // Sequencer: walks the pop loop, the push, and the chain read-out at the
  // end of a set. Holds off the input side until the word is done.
  ctsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: spine memory with registered read, cached top entry for the
  // compare, counters, and the output register that lets a result wait
  // while the sequencer moves on.
  ctsb_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

### tb/sv/cartesian_tree_stack_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartesian tree stack builder testbench
// Drives sets of signed keys into the builder under both heap orders and
// several idle and stall patterns. A behavioural spine stack in the bench
// predicts every edge and root record, and each result word is checked field
// by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module cartesian_tree_stack_builder_tb;

  localparam int ValW     = ctsb_pkg::ValW;
  localparam int IdxW     = ctsb_pkg::IdxW;
  localparam int MaxNodes = ctsb_pkg::MaxNodes;

  localparam int          CycleLimit   = 1000000;
  // a word that pops nothing may still be in flight once the queue is empty
  localparam int          SettleCycles = 8;
  localparam int          ReportLimit  = 10;
  localparam int          RandomWords  = 260;
  localparam logic [ValW-1:0] KeyMin   = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] KeyMax   = {1'b0, {(ValW-1){1'b1}}};

  // --------------------------------------------------------------------------
  // Clock, reset and the block's inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  ctsb_pkg::in_word_t  in_word     = '0;
  logic                out_stall   = 1'b0;
  logic                cfg_we      = 1'b0;
  logic                cfg_wdata   = 1'b1;

  logic                in_stall;
  logic                out_valid;
  ctsb_pkg::out_word_t out_word;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cartesian_tree_stack_builder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Behavioural copy of the builder: spine stack, numbering and mode
  // --------------------------------------------------------------------------
  logic                   heap_min_mode = 1'b1;
  logic [IdxW-1:0]        spine_node [MaxNodes];
  logic signed [ValW-1:0] spine_key  [MaxNodes];
  int unsigned            spine_depth  = 0;
  int unsigned            node_total   = 0;
  logic                   dropped_seen = 1'b0;

  ctsb_pkg::out_word_t expected_records[$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  longint    cycle_count    = 0;

  // strict compare, so equal keys keep their arrival order
  function automatic bit key_beats(logic signed [ValW-1:0] top,
                                   logic signed [ValW-1:0] key);
    if (heap_min_mode) begin
      return top > key;
    end
    return top < key;
  endfunction

  function automatic ctsb_pkg::out_word_t make_record(logic kind, logic [IdxW-1:0] parent,
                                                      logic [IdxW-1:0] child, logic ovf);
    ctsb_pkg::out_word_t r;
    r.record_kind = kind;
    r.parent_node = parent;
    r.child_node  = child;
    r.overflow    = ovf;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Work out every record that one accepted word causes and queue it.
  task automatic predict_tree_records(ctsb_pkg::in_word_t w);
    ctsb_pkg::out_word_t    run[$];
    logic [IdxW-1:0]        node;
    logic [IdxW-1:0]        prev;
    logic [IdxW-1:0]        top;
    logic signed [ValW-1:0] key;
    int unsigned            k;
    key = w.value;
    if (node_total < MaxNodes) begin
      node = IdxW'(node_total + 1);
      prev = '0;
      // pop everything that beats the new key; each pop parents the one before
      while (spine_depth > 0 && key_beats(spine_key[spine_depth-1], key)) begin
        top = spine_node[spine_depth-1];
        spine_depth--;
        if (prev != 0) begin
          run = {run, make_record(ctsb_pkg::KindEdge, top, prev, 1'b0)};
        end
        prev = top;
      end
      // the new node adopts the last popped entry, then joins the spine
      if (prev != 0) begin
        run = {run, make_record(ctsb_pkg::KindEdge, node, prev, 1'b0)};
      end
      spine_node[spine_depth] = node;
      spine_key[spine_depth]  = key;
      spine_depth++;
      node_total = node_total + 1;
    end else begin
      // capacity full: drop the key, remember it for the root record
      dropped_seen = 1'b1;
    end
    if (w.set_end) begin
      // close the set: the remaining spine is a chain, bottom entry is root
      for (k = 1; k < spine_depth; k++) begin
        run = {run, make_record(ctsb_pkg::KindEdge, spine_node[k-1], spine_node[k], 1'b0)};
      end
      run = {run, make_record(ctsb_pkg::KindRoot, '0, spine_node[0], dropped_seen)};
      spine_depth  = 0;
      node_total   = 0;
      dropped_seen = 1'b0;
    end
    if (run.size() > 0) begin
      run[run.size()-1].last_of_run = 1'b1;
    end
    foreach (run[i]) begin
      expected_records = {expected_records, run[i]};
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall and the record checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic note_mismatch(string what, ctsb_pkg::out_word_t want,
                               ctsb_pkg::out_word_t got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t: %s: expected kind=%0d parent=%0d child=%0d ovf=%0d last=%0d,",
               $realtime, what, want.record_kind, want.parent_node, want.child_node,
               want.overflow, want.last_of_run);
      $display("    got kind=%0d parent=%0d child=%0d ovf=%0d last=%0d",
               got.record_kind, got.parent_node, got.child_node, got.overflow,
               got.last_of_run);
    end
  endtask

  always @(posedge clk_i) begin : check_records
    ctsb_pkg::out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        note_mismatch("unexpected record", '0, out_word);
      end else begin
        want = expected_records.pop_front();
        if (out_word.record_kind !== want.record_kind ||
            out_word.parent_node !== want.parent_node ||
            out_word.child_node  !== want.child_node  ||
            out_word.overflow    !== want.overflow    ||
            out_word.last_of_run !== want.last_of_run) begin
          note_mismatch("record mismatch", want, out_word);
        end
      end
    end
  end

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // Offer one word and hold it until accepted; valid is only lowered for a gap,
  // so back-to-back words never drop and raise it in the same step.
  task automatic send_key(logic signed [ValW-1:0] key, logic last);
    ctsb_pkg::in_word_t w;
    w.value   = key;
    w.set_end = last;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    predict_tree_records(w);
  endtask

  // Pause the sender until every predicted record has come out, then let any
  // word that pops nothing finish its push.
  task automatic wait_all_records();
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the mode register, only with the block idle.
  task automatic write_heap_mode(logic min_mode);
    wait_all_records();
    cfg_we    <= 1'b1;
    cfg_wdata <= min_mode;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    heap_min_mode = min_mode;
  endtask

  function automatic logic signed [ValW-1:0] random_key();
    logic signed [ValW-1:0] k;
    case ($urandom_range(0, 6))
      0, 1, 2: k = {$urandom, $urandom};
      // narrow band: plenty of equal keys
      3, 4: k = ValW'($urandom_range(0, 6)) - 3;
      5: begin
        case ($urandom_range(0, 3))
          0: k = KeyMin;
          1: k = KeyMax;
          2: k = '0;
          default: k = '1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          k = KeyMin + ValW'($urandom_range(0, 3));
        end else begin
          k = KeyMax - ValW'($urandom_range(0, 3));
        end
      end
    endcase
    return k;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_min_heap_directed();
    write_heap_mode(1'b1);
    // single node set: root only
    send_key(KeyMax, 1'b1);
    // field extremes
    send_key(KeyMin, 1'b0);
    send_key(KeyMax, 1'b0);
    send_key('0, 1'b0);
    send_key('1, 1'b0);
    send_key(KeyMin, 1'b1);
    // equal keys stay a right chain
    repeat (3) send_key(64'sd5, 1'b0);
    send_key(64'sd5, 1'b1);
    // falling keys pop the whole spine each time
    send_key(64'sd4, 1'b0);
    send_key(64'sd3, 1'b0);
    send_key(64'sd2, 1'b0);
    send_key(64'sd1, 1'b1);
  endtask

  task automatic test_max_heap_directed();
    write_heap_mode(1'b0);
    send_key(64'sd1, 1'b0);
    send_key(64'sd2, 1'b0);
    send_key(64'sd3, 1'b0);
    send_key(64'sd4, 1'b1);
    send_key(KeyMax, 1'b0);
    send_key(KeyMin, 1'b0);
    send_key(KeyMax, 1'b1);
  endtask

  // Flip the order half way through a set: later compares use the new mode.
  task automatic test_mode_switch_in_set();
    write_heap_mode(1'b1);
    send_key(64'sd10, 1'b0);
    send_key(64'sd20, 1'b0);
    write_heap_mode(1'b0);
    send_key(64'sd30, 1'b0);
    send_key(64'sd5, 1'b1);
  endtask

  // A full set, then one that overruns and closes on a dropped key.
  task automatic test_capacity();
    int i;
    write_heap_mode(1'b1);
    for (i = 1; i <= MaxNodes; i++) begin
      send_key(random_key(), i == MaxNodes);
    end
    for (i = 1; i <= MaxNodes + 2; i++) begin
      send_key(random_key(), i == MaxNodes + 2);
      // hold off once mid-set until the block has drained
      if (i == MaxNodes / 2) begin
        wait_all_records();
      end
    end
  endtask

  // Mostly short sets with random content; now and then a set that overruns
  // capacity, a mid-set pause or a mid-set mode change.
  task automatic test_random_sets(int words);
    int sent;
    int set_len;
    int i;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 24) == 0) begin
        set_len = $urandom_range(MaxNodes - 2, MaxNodes + 4);
      end else begin
        set_len = $urandom_range(1, 10);
      end
      for (i = 1; i <= set_len; i++) begin
        send_key(random_key(), i == set_len);
        if (i != set_len) begin
          case ($urandom_range(0, 59))
            0: wait_all_records();
            1: write_heap_mode(1'($urandom_range(0, 1)));
            default: ;
          endcase
        end
      end
      sent += set_len;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_min_heap_directed();
    test_max_heap_directed();
    test_mode_switch_in_set();

    recv_stall_pct = 45;
    test_capacity();

    // idle phases: none, sender only, receiver only, both
    send_idle_pct = 0;  recv_stall_pct = 0;
    write_heap_mode(1'b1);
    test_random_sets(RandomWords / 4);
    send_idle_pct = 45; recv_stall_pct = 0;
    write_heap_mode(1'b0);
    test_random_sets(RandomWords / 4);
    send_idle_pct = 0;  recv_stall_pct = 45;
    write_heap_mode(1'b1);
    test_random_sets(RandomWords / 4);
    send_idle_pct = 22; recv_stall_pct = 22;
    write_heap_mode(1'($urandom_range(0, 1)));
    test_random_sets(RandomWords / 4);

    // drain, then give the block time to show any stray record
    wait_all_records();
    repeat (4 * SettleCycles) @(posedge clk_i);
    if (expected_records.size() != 0) begin
      mismatch_count += expected_records.size();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ctsb_pkg.sv
rtl/ctsb_ctrl.sv
rtl/ctsb_datapath.sv
rtl/cartesian_tree_stack_builder.sv
tb/sv/cartesian_tree_stack_builder_tb.sv
